// ===== sv/evs_pkg.sv =====
package evs_pkg;

   localparam int FRAME_LEN_DEFAULT    = 256;
   localparam int MAX_SEGMENTS_DEFAULT = 16;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int INDEX_WIDTH_DEFAULT  = 24;

   localparam int THR_WIDTH    = 39;
   localparam int OUT_WIDTH    = 24;
   localparam int STATUS_WIDTH = 2;

   localparam logic [THR_WIDTH-1:0] THR_RESET = 39'd1000000;

   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_FOUND    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_VOICE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_MANY = 2'd2;

   typedef struct packed {
      logic valid;
      logic full;
      logic last;
   } win_ctl_type;

   typedef struct packed {
      logic                    result_kind;
      logic [OUT_WIDTH-1:0]    seg_begin;
      logic [OUT_WIDTH-1:0]    seg_length;
      logic [STATUS_WIDTH-1:0] status;
      logic                    is_last;
   } rsp_word_type;

endpackage

// ===== sv/evs_cell.sv =====
module evs_cell #(
   parameter int SAMPLE_WIDTH = evs_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift,
   input  logic                           clear,
   input  logic signed [SAMPLE_WIDTH-1:0] d_sample,
   input  logic                           d_valid,
   output logic signed [SAMPLE_WIDTH-1:0] q_sample,
   output logic                           q_valid
);

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         valid_ff  <= 1'b0;
      end else if (shift) begin
         if (clear) begin
            sample_ff <= '0;
            valid_ff  <= 1'b0;
         end else begin
            sample_ff <= d_sample;
            valid_ff  <= d_valid;
         end
      end
   end

   assign q_sample = sample_ff;
   assign q_valid  = valid_ff;

endmodule

// ===== sv/evs_energy_pipe.sv =====
module evs_energy_pipe #(
   parameter int SAMPLE_WIDTH = evs_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int SUM_WIDTH    = 2 * evs_pkg::SAMPLE_WIDTH_DEFAULT - 1
                                + $clog2(evs_pkg::FRAME_LEN_DEFAULT)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           accept,
   input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] old_sample,
   input  logic                           full,
   input  logic                           last,
   output evs_pkg::win_ctl_type           win_ctl,
   output logic [SUM_WIDTH-1:0]           win_sum
);

   localparam int SQ_WIDTH = 2 * SAMPLE_WIDTH - 1;

   logic signed [2*SAMPLE_WIDTH-1:0] prod_new;
   logic signed [2*SAMPLE_WIDTH-1:0] prod_old;
   logic [SQ_WIDTH-1:0]              sq_new_ff;
   logic [SQ_WIDTH-1:0]              sq_old_ff;
   evs_pkg::win_ctl_type             s1_ctl_ff;
   evs_pkg::win_ctl_type             s2_ctl_ff;
   logic [SUM_WIDTH-1:0]             sum_ff;
   logic [SUM_WIDTH-1:0]             sum_in;
   logic [SUM_WIDTH-1:0]             s2_sum_ff;

   assign prod_new = new_sample * new_sample;
   assign prod_old = old_sample * old_sample;

   assign sum_in = sum_ff + SUM_WIDTH'(sq_new_ff) - SUM_WIDTH'(sq_old_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         sum_ff    <= '0;
      end else if (advance) begin
         s1_ctl_ff.valid <= accept;
         s1_ctl_ff.full  <= full;
         s1_ctl_ff.last  <= last;
         s2_ctl_ff       <= s1_ctl_ff;
         if (s1_ctl_ff.valid) begin
            sum_ff <= s1_ctl_ff.last ? '0 : sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_new_ff <= prod_new[SQ_WIDTH-1:0];
         sq_old_ff <= prod_old[SQ_WIDTH-1:0];
         s2_sum_ff <= sum_in;
      end
   end

   assign win_ctl = s2_ctl_ff;
   assign win_sum = s2_sum_ff;

endmodule

// ===== sv/evs_segmenter.sv =====
module evs_segmenter #(
   parameter int FRAME_LEN    = evs_pkg::FRAME_LEN_DEFAULT,
   parameter int MAX_SEGMENTS = evs_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int INDEX_WIDTH  = evs_pkg::INDEX_WIDTH_DEFAULT,
   parameter int SUM_WIDTH    = 2 * evs_pkg::SAMPLE_WIDTH_DEFAULT - 1
                                + $clog2(evs_pkg::FRAME_LEN_DEFAULT)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  evs_pkg::win_ctl_type              win_ctl,
   input  logic [SUM_WIDTH-1:0]              win_sum,
   input  logic [evs_pkg::THR_WIDTH-1:0]     threshold,
   output logic                              room,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output evs_pkg::rsp_word_type             rsp_word
);

   localparam int CMP_WIDTH  = (SUM_WIDTH > evs_pkg::THR_WIDTH) ? SUM_WIDTH
                                                                : evs_pkg::THR_WIDTH;
   localparam int SEG_WIDTH  = $clog2(MAX_SEGMENTS + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_WIDTH  = $clog2(FIFO_DEPTH);
   localparam int CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

   logic                   in_seg_ff;
   logic                   in_seg_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic [SEG_WIDTH-1:0]   seg_cnt_ff;
   logic [SEG_WIDTH-1:0]   seg_cnt_in;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [INDEX_WIDTH-1:0] idx_in;
   logic [INDEX_WIDTH-1:0] begin_ff;
   logic [INDEX_WIDTH-1:0] begin_in;

   logic                   fire;
   logic                   live;
   logic                   tested;
   logic                   voice;
   logic                   close;
   logic [INDEX_WIDTH-1:0] start;
   logic [SEG_WIDTH-1:0]   seg_cnt_inc;

   evs_pkg::rsp_word_type  rec_word;
   evs_pkg::rsp_word_type  stat_word;
   evs_pkg::rsp_word_type  first_word;

   evs_pkg::rsp_word_type  fifo_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic [CNT_WIDTH-1:0]   cnt_in;
   logic [1:0]             push_n;
   logic                   pop;

   assign fire        = advance && win_ctl.valid;
   assign live        = !ovf_ff;
   assign tested      = live && win_ctl.full;
   assign start       = idx_ff - INDEX_WIDTH'(FRAME_LEN - 1);
   assign voice       = CMP_WIDTH'(win_sum) > CMP_WIDTH'(threshold);
   assign close       = tested && !voice && in_seg_ff;
   assign seg_cnt_inc = seg_cnt_ff + 1'b1;

   always_comb begin
      in_seg_in  = in_seg_ff;
      begin_in   = begin_ff;
      seg_cnt_in = seg_cnt_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      if (tested) begin
         in_seg_in = voice;
         if (voice && !in_seg_ff) begin
            begin_in = start;
         end
      end
      if (close) begin
         seg_cnt_in = seg_cnt_inc;
         if (seg_cnt_inc >= SEG_WIDTH'(MAX_SEGMENTS)) begin
            ovf_in = 1'b1;
         end
      end
      if (live) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rec_word.result_kind = evs_pkg::KIND_SEGMENT;
      rec_word.seg_begin   = evs_pkg::OUT_WIDTH'(begin_ff);
      rec_word.seg_length  = evs_pkg::OUT_WIDTH'(start - begin_ff);
      rec_word.status      = evs_pkg::STATUS_FOUND;
      rec_word.is_last     = !win_ctl.last;

      stat_word.result_kind = evs_pkg::KIND_STATUS;
      stat_word.seg_begin   = '0;
      stat_word.seg_length  = '0;
      stat_word.is_last     = 1'b1;
      if (ovf_in) begin
         stat_word.status = evs_pkg::STATUS_TOO_MANY;
      end else if (seg_cnt_in == '0) begin
         stat_word.status = evs_pkg::STATUS_NO_VOICE;
      end else begin
         stat_word.status = evs_pkg::STATUS_FOUND;
      end

      first_word = close ? rec_word : stat_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_seg_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
         seg_cnt_ff <= '0;
         idx_ff     <= '0;
         begin_ff   <= '0;
      end else if (fire) begin
         if (win_ctl.last) begin
            in_seg_ff  <= 1'b0;
            ovf_ff     <= 1'b0;
            seg_cnt_ff <= '0;
            idx_ff     <= '0;
            begin_ff   <= '0;
         end else begin
            in_seg_ff  <= in_seg_in;
            ovf_ff     <= ovf_in;
            seg_cnt_ff <= seg_cnt_in;
            idx_ff     <= idx_in;
            begin_ff   <= begin_in;
         end
      end
   end

   assign push_n    = fire ? (2'(close) + 2'(win_ctl.last)) : 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
   assign cnt_in    = cnt_ff + CNT_WIDTH'(push_n) - CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= first_word;
      end
      if (push_n == 2'd2) begin
         fifo_ff[PTR_WIDTH'(wr_ptr_ff + 1'b1)] <= stat_word;
      end
   end

   assign room      = cnt_ff <= CNT_WIDTH'(FIFO_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_word  = fifo_ff[rd_ptr_ff];

endmodule

// ===== sv/energy_vad_segmenter_top.sv =====
// Energy based voice activity segmenter.
// Input channel req_*: one signed audio sample per word, req_last_sample
// marks the final sample of a buffer. Output channel rsp_*: segment records
// (begin index and length in window positions) and one end-of-audio status
// word per buffer; rsp_is_last flags the final word caused by an input.
// csr_wr_en/csr_wr_data write the energy threshold; write it only while idle.
// Samples shift through a row of FRAME_LEN cells; two squarers and the
// running sum form a two stage pipe, then the decision writes a four word
// result queue. Throughput is one sample per cycle unless the pipe stalls.
// The pipe stalls, dropping req_ready, only while a sample waits at the
// decision and the queue has fewer than two free words, i.e. when
// rsp_ready holds low.
// Reset clears the window cells, the sum, the segment state and the queue,
// and loads the threshold with its default; after each final sample the
// window and segment state return to that cleared state on their own.
module energy_vad_segmenter_top #(
   parameter int FRAME_LEN    = evs_pkg::FRAME_LEN_DEFAULT,
   parameter int MAX_SEGMENTS = evs_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int SAMPLE_WIDTH = evs_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH  = evs_pkg::INDEX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_result_kind,
   output logic [evs_pkg::OUT_WIDTH-1:0]       rsp_seg_begin,
   output logic [evs_pkg::OUT_WIDTH-1:0]       rsp_seg_length,
   output logic [evs_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic                                rsp_is_last,
   input  logic                                csr_wr_en,
   input  logic [evs_pkg::THR_WIDTH-1:0]       csr_wr_data
);

   localparam int SUM_WIDTH = 2 * SAMPLE_WIDTH - 1 + $clog2(FRAME_LEN);

   logic [evs_pkg::THR_WIDTH-1:0]  thr_ff;
   logic                           advance;
   logic                           accept;
   logic                           room;
   logic signed [SAMPLE_WIDTH-1:0] chain_sample [FRAME_LEN];
   logic [FRAME_LEN-1:0]           chain_valid;
   evs_pkg::win_ctl_type           win_ctl;
   logic [SUM_WIDTH-1:0]           win_sum;
   evs_pkg::rsp_word_type          rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= evs_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   assign advance   = room || !win_ctl.valid;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   genvar i;
   generate
      for (i = 0; i < FRAME_LEN; i++) begin : g_cell
         if (i == 0) begin : g_head
            evs_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (accept),
               .clear    (req_last_sample),
               .d_sample (req_sample),
               .d_valid  (1'b1),
               .q_sample (chain_sample[i]),
               .q_valid  (chain_valid[i])
            );
         end else begin : g_body
            evs_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (accept),
               .clear    (req_last_sample),
               .d_sample (chain_sample[i-1]),
               .d_valid  (chain_valid[i-1]),
               .q_sample (chain_sample[i]),
               .q_valid  (chain_valid[i])
            );
         end
      end
   endgenerate

   evs_energy_pipe #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_energy (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .accept     (accept),
      .new_sample (req_sample),
      .old_sample (chain_sample[FRAME_LEN-1]),
      .full       (chain_valid[FRAME_LEN-2]),
      .last       (req_last_sample),
      .win_ctl    (win_ctl),
      .win_sum    (win_sum)
   );

   evs_segmenter #(
      .FRAME_LEN    (FRAME_LEN),
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .INDEX_WIDTH  (INDEX_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_segmenter (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .win_ctl   (win_ctl),
      .win_sum   (win_sum),
      .threshold (thr_ff),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_result_kind = rsp_word.result_kind;
   assign rsp_seg_begin   = rsp_word.seg_begin;
   assign rsp_seg_length  = rsp_word.seg_length;
   assign rsp_status      = rsp_word.status;
   assign rsp_is_last     = rsp_word.is_last;

   // hold off new samples only when a word is waiting at the decision
   a_stall_cause: assert property (@(posedge clock)
      !req_ready |-> win_ctl.valid)
      else $error("input stalled with no word at the decision");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == evs_pkg::KIND_STATUS |->
         rsp_is_last && rsp_seg_begin == '0 && rsp_seg_length == '0)
      else $error("malformed status word");

   a_record_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == evs_pkg::KIND_SEGMENT |->
         rsp_status == evs_pkg::STATUS_FOUND)
      else $error("segment record carries a status code");

endmodule

// ===== bench/tb_energy_vad_segmenter_top.sv =====
module tb_energy_vad_segmenter_top;
   import evs_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_LIMIT   = 30;
   localparam int SHAPE_TRACK   = 0;
   localparam int SHAPE_NOISE   = 1;
   localparam int TOGGLE_TAIL   = 40;

   localparam logic [THR_WIDTH-1:0] THR_CEIL = 39'h40_0000_0000;
   localparam longint unsigned FULL_SQ = 64'd32767 * 64'd32767;
   localparam logic [THR_WIDTH-1:0] THR_TOGGLE = THR_WIDTH'(FULL_SQ * 128 - FULL_SQ / 2);

   logic clock;
   logic reset = 1'b1;

   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic signed [15:0]      req_sample      = '0;
   logic                    req_last_sample = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic                    rsp_result_kind;
   logic [OUT_WIDTH-1:0]    rsp_seg_begin;
   logic [OUT_WIDTH-1:0]    rsp_seg_length;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic                    rsp_is_last;
   logic                    csr_wr_en       = 1'b0;
   logic [THR_WIDTH-1:0]    csr_wr_data     = '0;

   logic signed [15:0]   win_cells [FRAME_LEN_DEFAULT];
   logic [THR_WIDTH:0]   win_energy;
   logic [THR_WIDTH-1:0] energy_limit = THR_RESET;
   logic                 voiced_run;
   logic                 capped;
   int                   closed_count;
   int                   cell_ptr;
   int                   cells_filled;
   logic [OUT_WIDTH-1:0] next_index;
   logic [OUT_WIDTH-1:0] run_begin;

   rsp_word_type vad_words [$];

   int mismatches   = 0;
   int live_samples = 0;
   int cycle_count  = 0;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int rx_hold_req  = 0;
   int hold_left    = 0;

   energy_vad_segmenter_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_seg_begin   (rsp_seg_begin),
      .rsp_seg_length  (rsp_seg_length),
      .rsp_status      (rsp_status),
      .rsp_is_last     (rsp_is_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic rsp_word_type vad_word(logic kind, logic [OUT_WIDTH-1:0] seg_b,
                                             logic [OUT_WIDTH-1:0] seg_l,
                                             logic [STATUS_WIDTH-1:0] st, logic fin);
      rsp_word_type w;
      w.result_kind = kind;
      w.seg_begin   = seg_b;
      w.seg_length  = seg_l;
      w.status      = st;
      w.is_last     = fin;
      return w;
   endfunction

   function void clear_window();
      for (int k = 0; k < FRAME_LEN_DEFAULT; k++) win_cells[k] = '0;
      win_energy   = '0;
      voiced_run   = 1'b0;
      capped       = 1'b0;
      closed_count = 0;
      cell_ptr     = 0;
      cells_filled = 0;
      next_index   = '0;
      run_begin    = '0;
   endfunction

   task automatic advance_window(input logic signed [15:0] smp, input logic last_flag);
      logic [31:0]          old_sq;
      logic [31:0]          new_sq;
      logic [OUT_WIDTH-1:0] start;
      logic                 closed;
      rsp_word_type         seg_word;
      closed = 1'b0;
      if (!capped) begin
         old_sq = win_cells[cell_ptr] * win_cells[cell_ptr];
         new_sq = smp * smp;
         win_energy = win_energy - old_sq + new_sq;
         win_cells[cell_ptr] = smp;
         cell_ptr = (cell_ptr + 1) % FRAME_LEN_DEFAULT;
         if (cells_filled < FRAME_LEN_DEFAULT) cells_filled++;
         if (cells_filled == FRAME_LEN_DEFAULT) begin
            start = next_index - OUT_WIDTH'(FRAME_LEN_DEFAULT - 1);
            if (win_energy > energy_limit) begin
               if (!voiced_run) run_begin = start;
               voiced_run = 1'b1;
            end else begin
               if (voiced_run) begin
                  closed = 1'b1;
                  seg_word = vad_word(KIND_SEGMENT, run_begin, start - run_begin,
                                      STATUS_FOUND, !last_flag);
                  closed_count++;
                  if (closed_count >= MAX_SEGMENTS_DEFAULT) capped = 1'b1;
               end
               voiced_run = 1'b0;
            end
         end
         next_index = next_index + 1'b1;
      end
      if (closed) vad_words.push_back(seg_word);
      if (last_flag) begin
         vad_words.push_back(vad_word(KIND_STATUS, '0, '0,
                                      capped ? STATUS_TOO_MANY :
                                      (closed_count == 0 ? STATUS_NO_VOICE : STATUS_FOUND),
                                      1'b1));
         clear_window();
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
      mismatches++;
   endtask

   task automatic send_sample(input logic signed [15:0] smp, input logic last_flag);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= smp;
      req_last_sample <= last_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!capped) live_samples++;
      advance_window(smp, last_flag);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (vad_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_WIDTH-1:0] thr);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      energy_limit = thr;
   endtask

   // steer each sample so the window energy hovers around the threshold (noise shape: random samples)
   task automatic send_buffer(input int len, input int shape);
      logic signed [15:0] smp;
      logic               last_flag;
      logic               loud;
      int                 mag;
      int                 tail_left;
      tail_left = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         last_flag = (i == len - 1) || (capped && tail_left == 0);
         if (shape == SHAPE_NOISE) begin
            smp = 16'($urandom);
         end else begin
            loud = !(win_energy > energy_limit);
            if ($urandom_range(99) < 20) loud = !loud;
            mag = loud ? $urandom_range(8192, 32767) : $urandom_range(0, 255);
            smp = $urandom_range(1) ? 16'(-mag) : 16'(mag);
            if (loud && $urandom_range(15) == 0) smp = 16'sh8000;
         end
         send_sample(smp, last_flag);
         if (last_flag) break;
         if (capped) tail_left--;
      end
   endtask

   // alternate voiced and unvoiced windows on every sample once the first window fills
   task automatic send_toggle_buffer();
      for (int j = 0; j < FRAME_LEN_DEFAULT; j++)
         send_sample((j % 2 == 0) ? 16'sd32767 : 16'sd0, 1'b0);
      for (int j = 0; j < TOGGLE_TAIL; j++)
         send_sample((j % 2 == 1) ? 16'sd32767 : 16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int quota);
      int                   base;
      int                   len;
      logic [63:0]          r64;
      logic [THR_WIDTH-1:0] thr;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      base = live_samples;
      while (live_samples - base < quota) begin
         r64 = {$urandom, $urandom};
         case ($urandom_range(9))
            0:       thr = '0;
            1:       thr = THR_CEIL;
            2:       thr = THR_CEIL - 1'b1;
            default: thr = r64[THR_WIDTH-1:0] >> $urandom_range(1, 16);
         endcase
         write_threshold(thr);
         len = ($urandom_range(9) == 0) ? $urandom_range(1, FRAME_LEN_DEFAULT - 1)
                                        : $urandom_range(FRAME_LEN_DEFAULT, 480);
         send_buffer(len, ($urandom_range(4) == 0) ? SHAPE_NOISE : SHAPE_TRACK);
      end
   endtask

   task automatic test_short_audio();
      send_sample(16'sd32767, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd0, 1'b1);
   endtask

   task automatic test_threshold_edges();
      write_threshold(THR_CEIL - 1'b1);
      for (int j = 0; j < FRAME_LEN_DEFAULT; j++) send_sample(16'sh8000, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      write_threshold(THR_CEIL);
      for (int j = 0; j < FRAME_LEN_DEFAULT; j++)
         send_sample(16'sh8000, j == FRAME_LEN_DEFAULT - 1);
      // open segment at the end is dropped
      write_threshold('0);
      for (int j = 0; j < FRAME_LEN_DEFAULT; j++) send_sample(16'sd0, 1'b0);
      send_sample(16'sd5, 1'b1);
   endtask

   task automatic test_segment_overflow();
      write_threshold(THR_TOGGLE);
      send_toggle_buffer();
   endtask

   task automatic test_output_hold();
      write_threshold(THR_TOGGLE);
      rx_hold_req = HOLD_CYCLES;
      send_toggle_buffer();
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 360);
      run_phase(49, 0, 360);
      run_phase(0, 49, 360);
      run_phase(17, 17, 370);
   endtask

   always @(posedge clock) begin
      if (rx_hold_req != 0) begin
         hold_left   = rx_hold_req;
         rx_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vad_words.size() == 0) begin
            report_mismatch("word with none pending, kind", rsp_result_kind, 0);
         end else begin
            want = vad_words.pop_front();
            if (rsp_result_kind !== want.result_kind)
               report_mismatch("result_kind", rsp_result_kind, want.result_kind);
            if (rsp_seg_begin !== want.seg_begin)
               report_mismatch("seg_begin", rsp_seg_begin, want.seg_begin);
            if (rsp_seg_length !== want.seg_length)
               report_mismatch("seg_length", rsp_seg_length, want.seg_length);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_is_last !== want.is_last)
               report_mismatch("is_last", rsp_is_last, want.is_last);
         end
      end
   end

   initial begin
      clear_window();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_short_audio();
      test_threshold_edges();
      test_segment_overflow();
      test_output_hold();
      test_random_traffic();
      settle_block();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/evs_pkg.sv
sv/evs_cell.sv
sv/evs_energy_pipe.sv
sv/evs_segmenter.sv
sv/energy_vad_segmenter_top.sv
bench/tb_energy_vad_segmenter_top.sv
